// ===== rtl/core/fsrs_pkg.sv =====
// Package with the shared types and codes of the failsafe response selector.
`default_nettype none
package fsrs_pkg;

    localparam logic [1:0] OP_RADIO_LOST     = 2'd0;
    localparam logic [1:0] OP_RADIO_REGAINED = 2'd1;
    localparam logic [1:0] OP_BATTERY_LOW    = 2'd2;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_DISARM = 2'd1;
    localparam logic [1:0] ACT_LAND   = 2'd2;
    localparam logic [1:0] ACT_RTL    = 2'd3;

    localparam logic [1:0] LOG_NONE     = 2'd0;
    localparam logic [1:0] LOG_RADIO_FS = 2'd1;
    localparam logic [1:0] LOG_RADIO_OK = 2'd2;
    localparam logic [1:0] LOG_BATT_FS  = 2'd3;

    localparam logic [2:0] MODE_STABILIZE = 3'd0;
    localparam logic [2:0] MODE_ACRO      = 3'd1;
    localparam logic [2:0] MODE_SPORT     = 3'd2;
    localparam logic [2:0] MODE_AUTO      = 3'd3;
    localparam logic [2:0] MODE_LOITER    = 3'd4;
    localparam logic [2:0] MODE_ALT_HOLD  = 3'd5;
    localparam logic [2:0] MODE_LAND      = 3'd6;

    localparam logic [1:0] TP_ALWAYS_RTL  = 2'd1;
    localparam logic [1:0] TP_ALWAYS_LAND = 2'd3;

    localparam logic [1:0] BP_DISABLED = 2'd0;
    localparam logic [1:0] BP_LAND     = 2'd1;
    localparam logic [1:0] BP_RTL      = 2'd2;

    localparam logic [1:0] REG_THROTTLE_POLICY = 2'd0;
    localparam logic [1:0] REG_BATTERY_POLICY  = 2'd1;
    localparam logic [1:0] REG_WAYPOINT_RADIUS = 2'd2;

    localparam logic [1:0]  RST_THROTTLE_POLICY = 2'd3;
    localparam logic [1:0]  RST_BATTERY_POLICY  = 2'd0;
    localparam logic [23:0] RST_WAYPOINT_RADIUS = 24'd200;

    typedef struct packed {
        logic [1:0]  operation;
        logic        motors_armed;
        logic [2:0]  flight_mode;
        logic [9:0]  throttle_in;
        logic        landed;
        logic [23:0] home_range;
        logic        rtl_allowed;
    } t_event;

    typedef struct packed {
        logic [1:0]  throttle_policy;
        logic [1:0]  battery_policy;
        logic [23:0] waypoint_radius;
    } t_cfg;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] log_code;
        logic       battery_failsafe_active;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/fsrs_ifs.sv =====
// Channel interfaces for events, results and configuration writes.
`default_nettype none
interface fsrs_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        motors_armed;
    logic [2:0]  flight_mode;
    logic [9:0]  throttle_in;
    logic        landed;
    logic [23:0] home_range;
    logic        rtl_allowed;
    modport source(output valid, operation, motors_armed, flight_mode, throttle_in,
                   landed, home_range, rtl_allowed, input ready);
    modport sink(input valid, operation, motors_armed, flight_mode, throttle_in,
                 landed, home_range, rtl_allowed, output ready);
endinterface

interface fsrs_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [1:0] log_code;
    logic       battery_failsafe_active;
    modport source(output valid, action, log_code, battery_failsafe_active, input ready);
    modport sink(input valid, action, log_code, battery_failsafe_active, output ready);
endinterface

interface fsrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fsrs_decide.sv =====
// Response decision logic for one registered failsafe event.
`default_nettype none
module fsrs_decide
    import fsrs_pkg::*;
(
    input  t_event  i_evt,
    input  t_cfg    i_cfg,
    input  logic    i_latched,
    output t_result o_res
);

    logic       stick_down;
    logic       far;
    logic       land_now;
    logic [1:0] home_act;
    logic [1:0] home_batt_act;
    logic [1:0] radio_act;
    logic       radio_done;
    logic [1:0] batt_act;
    logic       batt_done;

    assign stick_down    = (i_evt.throttle_in == 10'd0);
    assign far           = (i_evt.home_range > i_cfg.waypoint_radius);
    assign land_now      = (i_cfg.throttle_policy == TP_ALWAYS_LAND);
    assign home_act      = (far && i_evt.rtl_allowed) ? ACT_RTL : ACT_LAND;
    assign home_batt_act = (i_cfg.battery_policy == BP_RTL && far && i_evt.rtl_allowed)
                           ? ACT_RTL : ACT_LAND;

    always_comb begin
        radio_act  = ACT_NONE;
        radio_done = 1'b0;
        case (i_evt.flight_mode)
            MODE_STABILIZE, MODE_ACRO, MODE_SPORT: begin
                if (stick_down) begin
                    radio_act  = ACT_DISARM;
                    radio_done = 1'b1;
                end
            end
            MODE_AUTO: begin
                radio_done = 1'b1;
                if (i_cfg.throttle_policy == TP_ALWAYS_RTL) begin
                    radio_act = home_act;
                end else if (land_now) begin
                    radio_act = ACT_LAND;
                end else begin
                    radio_act = ACT_NONE;
                end
            end
            MODE_LOITER, MODE_ALT_HOLD: begin
                if (stick_down && i_evt.landed) begin
                    radio_act  = ACT_DISARM;
                    radio_done = 1'b1;
                end
            end
            MODE_LAND: begin
                if (i_cfg.battery_policy == BP_LAND && i_latched) begin
                    radio_act  = ACT_NONE;
                    radio_done = 1'b1;
                end
            end
            default: begin
                radio_done = 1'b0;
            end
        endcase
        if (!radio_done) begin
            radio_act = land_now ? ACT_LAND : home_act;
        end
    end

    always_comb begin
        batt_act  = ACT_NONE;
        batt_done = 1'b0;
        case (i_evt.flight_mode)
            MODE_STABILIZE, MODE_ACRO, MODE_SPORT: begin
                if (stick_down) begin
                    batt_act  = ACT_DISARM;
                    batt_done = 1'b1;
                end
            end
            MODE_AUTO: begin
                batt_act  = home_act;
                batt_done = 1'b1;
            end
            MODE_LOITER, MODE_ALT_HOLD: begin
                if (stick_down && i_evt.landed) begin
                    batt_act  = ACT_DISARM;
                    batt_done = 1'b1;
                end
            end
            default: begin
                batt_done = 1'b0;
            end
        endcase
        if (!batt_done) begin
            batt_act = home_batt_act;
        end
    end

    always_comb begin
        o_res.action                  = ACT_NONE;
        o_res.log_code                = LOG_NONE;
        o_res.battery_failsafe_active = i_latched;
        case (i_evt.operation)
            OP_RADIO_LOST: begin
                if (i_evt.motors_armed) begin
                    o_res.action   = radio_act;
                    o_res.log_code = LOG_RADIO_FS;
                end
            end
            OP_RADIO_REGAINED: begin
                o_res.log_code = LOG_RADIO_OK;
            end
            OP_BATTERY_LOW: begin
                if (!i_latched) begin
                    if (i_cfg.battery_policy != BP_DISABLED && i_evt.motors_armed) begin
                        o_res.action = batt_act;
                    end
                    o_res.battery_failsafe_active = 1'b1;
                    o_res.log_code                = LOG_BATT_FS;
                end
            end
            default: begin
                o_res.action = ACT_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/failsafe_response_selector_top.sv =====
// Top level of the failsafe response selector: event register, decision, result register.
//
//   channel   direction  handshake      payload
//   i_evt     in         valid/ready    operation .. rtl_allowed
//   o_res     out        valid/ready    action, log_code, battery_failsafe_active
//   i_cfg     in         valid/ready    index, data (always ready)
//
// An accepted item is registered in the event register and its result then in the
// result register; one item is taken in every cycle while the output is not stalled.
// The synchronous reset clears the valid flags and the battery latch and sets the
// configuration registers to their reset values. A stalled result holds while the event
// register still takes one more item; the input stalls only when both stages are full.
`default_nettype none
module failsafe_response_selector_top
    import fsrs_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    fsrs_evt_if.sink     i_evt,
    fsrs_res_if.source   o_res,
    fsrs_cfg_if.sink     i_cfg
);

    logic    r_s1_valid;
    t_event  r_s1_evt;
    logic    r_out_valid;
    t_result r_out;
    t_cfg    r_cfg;
    logic    r_latched;

    t_result n_out;
    logic    s1_advance;
    logic    evt_accept;

    assign s1_advance = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_s1_valid || s1_advance;
    assign evt_accept  = i_evt.valid && i_evt.ready;
    assign i_cfg.ready = 1'b1;

    fsrs_decide u_decide (
        .i_evt     (r_s1_evt),
        .i_cfg     (r_cfg),
        .i_latched (r_latched),
        .o_res     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_latched   <= 1'b0;
            r_cfg.throttle_policy <= RST_THROTTLE_POLICY;
            r_cfg.battery_policy  <= RST_BATTERY_POLICY;
            r_cfg.waypoint_radius <= RST_WAYPOINT_RADIUS;
        end else begin
            if (evt_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_latched   <= n_out.battery_failsafe_active;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_THROTTLE_POLICY: r_cfg.throttle_policy <= i_cfg.data[1:0];
                    REG_BATTERY_POLICY:  r_cfg.battery_policy  <= i_cfg.data[1:0];
                    REG_WAYPOINT_RADIUS: r_cfg.waypoint_radius <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt_accept) begin
            r_s1_evt.operation     <= i_evt.operation;
            r_s1_evt.motors_armed  <= i_evt.motors_armed;
            r_s1_evt.flight_mode   <= i_evt.flight_mode;
            r_s1_evt.throttle_in   <= i_evt.throttle_in;
            r_s1_evt.landed        <= i_evt.landed;
            r_s1_evt.home_range    <= i_evt.home_range;
            r_s1_evt.rtl_allowed   <= i_evt.rtl_allowed;
        end
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid                   = r_out_valid;
    assign o_res.action                  = r_out.action;
    assign o_res.log_code                = r_out.log_code;
    assign o_res.battery_failsafe_active = r_out.battery_failsafe_active;

endmodule
`default_nettype wire
